[sv/lsms_pkg.sv]
// Shared types and constants for the load/store-multiple sequencer.
package lsms_pkg;

    localparam int unsigned NUM_REGS    = 16;
    localparam int unsigned REG_IDX_W   = $clog2(NUM_REGS);
    localparam int unsigned COUNT_W     = $clog2(NUM_REGS + 1);
    localparam int unsigned SPAN_W      = COUNT_W + 2;
    localparam int unsigned WORD_W      = 32;
    localparam logic [WORD_W-1:0] WORD_BYTES = 32'd4;

    // first halfword decode
    localparam int unsigned HW_INC_BIT  = 7;
    localparam int unsigned HW_WB_BIT   = 5;
    localparam int unsigned HW_LOAD_BIT = 4;

    typedef struct packed {
        logic [15:0]       first_halfword;
        logic [15:0]       register_list;
        logic [WORD_W-1:0] base_value;
        logic [WORD_W-1:0] pc_value;
    } t_in_txn;

    typedef struct packed {
        logic                 illegal;
        logic                 is_load;
        logic [WORD_W-1:0]    access_address;
        logic [REG_IDX_W-1:0] reg_index;
        logic [WORD_W-1:0]    pc_store_value;
        logic                 do_writeback;
        logic [REG_IDX_W-1:0] writeback_reg;
        logic [WORD_W-1:0]    writeback_value;
        logic                 last;
    } t_out_txn;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WBACK,
        S_PC,
        S_EMIT
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

[sv/lsms_alu.sv]
// Shared 32-bit add/subtract unit used for every address computation.
module lsms_alu
    import lsms_pkg::*;
(
    input  t_alu_op           i_op,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic [WORD_W-1:0] o_result
);

    always_comb begin
        case (i_op)
            ALU_ADD: o_result = i_a + i_b;
            ALU_SUB: o_result = i_a - i_b;
            default: o_result = i_a + i_b;
        endcase
    end

endmodule

[sv/load_store_multiple_sequencer_top.sv]
// Top level of the load/store-multiple sequencer.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one transaction is one
// load/store-multiple instruction with base register value and PC.
// Output channel (o_out_valid / i_out_ready / o_out_data): one transaction per
// set bit of the register list, ascending register order; the final one has
// last set and carries the base writeback when requested. An empty list gives
// a single transaction with illegal and last set, all other fields zero.
//
// Sequence: after acceptance, the single shared adder forms the start address,
// the writeback value and PC+4 in the states START, WBACK and PC; then EMIT
// gives one access per cycle while the receiver does not stall, the adder
// stepping the address by four. An empty list goes straight from idle to EMIT.
// o_in_ready is high only in idle, so a new instruction is taken only after
// the previous one has emitted its last transaction.
//
// A receiver stall simply holds the output register; the sequencer waits in EMIT.
// Synchronous active-low reset returns to idle with no output pending.
module load_store_multiple_sequencer_top
    import lsms_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_txn  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_txn o_out_data
);

    // control state
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // instruction context
    logic                 r_inc, r_wb, r_load, r_illegal;
    logic [REG_IDX_W-1:0] r_rn;
    logic [15:0]          r_list, n_list;
    logic [SPAN_W-1:0]    r_span;
    logic [WORD_W-1:0]    r_base, r_pc, r_addr, r_wb_value, r_pcs;
    t_out_txn             r_out, n_out;

    // shared adder
    t_alu_op           alu_op;
    logic [WORD_W-1:0] alu_a, alu_b, alu_res;

    logic                 in_fire;
    logic                 out_free;
    logic                 emit;
    logic [COUNT_W-1:0]   in_count;
    logic [REG_IDX_W-1:0] low_idx;
    logic                 list_last;
    logic [15:0]          list_minus1;

    lsms_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_result (alu_res)
    );

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign emit     = (r_state == S_EMIT) && out_free;

    // number of registers in the incoming list
    always_comb begin
        in_count = '0;
        for (int i = 0; i < NUM_REGS; i++) begin
            in_count = in_count + COUNT_W'(i_in_data.register_list[i]);
        end
    end

    // lowest remaining register
    always_comb begin
        low_idx = '0;
        for (int i = NUM_REGS - 1; i >= 0; i--) begin
            if (r_list[i]) begin
                low_idx = REG_IDX_W'(i);
            end
        end
    end

    assign list_minus1 = r_list - 16'd1;
    assign list_last   = ((r_list & list_minus1) == 16'd0);

    // adder operand selection per sequencer step
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = r_addr;
        alu_b  = WORD_BYTES;
        case (r_state)
            S_START: begin
                alu_a  = r_base;
                alu_b  = r_inc ? '0 : WORD_W'(r_span);
                alu_op = r_inc ? ALU_ADD : ALU_SUB;
            end
            S_WBACK: begin
                alu_a  = r_base;
                alu_b  = WORD_W'(r_span);
                alu_op = r_inc ? ALU_ADD : ALU_SUB;
            end
            S_PC: begin
                alu_a = r_pc;
            end
            default: begin
                alu_a = r_addr;
            end
        endcase
    end

    // next state and output register
    always_comb begin
        n_state     = r_state;
        n_list      = r_list;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_list  = i_in_data.register_list;
                    n_state = (in_count == '0) ? S_EMIT : S_START;
                end
            end
            S_START: n_state = S_WBACK;
            S_WBACK: n_state = S_PC;
            S_PC:    n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    if (r_illegal) begin
                        n_out.illegal = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_out.is_load        = r_load;
                        n_out.access_address = r_addr;
                        n_out.reg_index      = low_idx;
                        n_out.pc_store_value = r_pcs;
                        n_out.last           = list_last;
                        if (list_last && r_wb) begin
                            n_out.do_writeback    = 1'b1;
                            n_out.writeback_reg   = r_rn;
                            n_out.writeback_value = r_wb_value;
                        end
                        n_list = r_list & list_minus1;
                        if (list_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_list <= n_list;
        r_out  <= n_out;
        if (in_fire) begin
            r_inc     <= i_in_data.first_halfword[HW_INC_BIT];
            r_wb      <= i_in_data.first_halfword[HW_WB_BIT];
            r_load    <= i_in_data.first_halfword[HW_LOAD_BIT];
            r_rn      <= i_in_data.first_halfword[REG_IDX_W-1:0];
            r_illegal <= (in_count == '0);
            r_span    <= {in_count, 2'b00};
            r_base    <= i_in_data.base_value;
            r_pc      <= i_in_data.pc_value;
        end
        if (r_state == S_START || emit) begin
            r_addr <= alu_res;
        end
        if (r_state == S_WBACK) begin
            r_wb_value <= alu_res;
        end
        if (r_state == S_PC) begin
            r_pcs <= alu_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an illegal result always closes its instruction
    a_illegal_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.illegal) |-> o_out_data.last)
        else $error("illegal result without last");

    // writeback only rides on the final access
    a_wb_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.do_writeback) |-> o_out_data.last)
        else $error("writeback on non-final access");

    // a legal instruction never reaches the emit step with nothing left
    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_illegal) |-> (r_list != 16'd0))
        else $error("emit step with empty register list");

    // an accepted instruction always leaves idle
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("accepted instruction dropped");

endmodule
